@@ rtl/assert_macros.svh @@
// assertion macros shared by the point table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define KNP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is held
`define KNP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/knp_pkg.sv @@
// shared types and constants of the nearest point table
package knp_pkg;

  localparam int COORD_W = 16;
  localparam int DIST_W  = 33;
  localparam int PIDX_W  = 10;
  localparam int K_W     = 7;
  localparam int STAT_W  = 3;
  localparam int OP_W    = 2;

  localparam logic [K_W-1:0] K_RESET = 7'd16;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NEIGHBOR = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd4;

  typedef struct packed {
    logic clr;
    logic ins;
    logic shift;
  } cell_ctl_t;

endpackage

@@ rtl/knp_ram.sv @@
// generic single-write, registered-read memory
module knp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/knp_dist.sv @@
// three-stage squared distance pipeline
module knp_dist #(
  parameter int IDX_W = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [IDX_W-1:0]                  in_idx,
  input  logic signed [knp_pkg::COORD_W-1:0] px,
  input  logic signed [knp_pkg::COORD_W-1:0] py,
  input  logic signed [knp_pkg::COORD_W-1:0] qx,
  input  logic signed [knp_pkg::COORD_W-1:0] qy,
  output logic                              out_valid,
  output logic [IDX_W-1:0]                  out_idx,
  output logic [knp_pkg::DIST_W-1:0]        out_dist,
  output logic                              busy
);

  localparam int CW = knp_pkg::COORD_W;

  logic signed [CW:0] dx, dy;
  logic [CW-1:0]      ax_nxt, ay_nxt;

  logic [2:0]         v_r;
  logic [IDX_W-1:0]   idx1_r, idx2_r, idx3_r;
  logic [CW-1:0]      ax_r, ay_r;
  logic [2*CW-1:0]    sqx_r, sqy_r;
  logic [knp_pkg::DIST_W-1:0] sum_r;

  always_comb begin
    dx = (CW+1)'(px) - (CW+1)'(qx);
    dy = (CW+1)'(py) - (CW+1)'(qy);
    // magnitude of a 17-bit difference fits in 16 bits
    ax_nxt = dx[CW] ? CW'(-dx) : CW'(dx);
    ay_nxt = dy[CW] ? CW'(-dy) : CW'(dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
    idx1_r <= in_idx;
    sqx_r  <= (2*CW)'(ax_r) * (2*CW)'(ax_r);
    sqy_r  <= (2*CW)'(ay_r) * (2*CW)'(ay_r);
    idx2_r <= idx1_r;
    sum_r  <= knp_pkg::DIST_W'(sqx_r) + knp_pkg::DIST_W'(sqy_r);
    idx3_r <= idx2_r;
  end

  assign out_valid = v_r[2];
  assign out_idx   = idx3_r;
  assign out_dist  = sum_r;
  assign busy      = |v_r;

endmodule

@@ rtl/knp_cell.sv @@
// one slot of the sorted neighbor chain
module knp_cell #(
  parameter int IDX_W = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  knp_pkg::cell_ctl_t          ctl,
  input  logic [knp_pkg::DIST_W-1:0]  cand_dist,
  input  logic [IDX_W-1:0]            cand_idx,
  input  logic                        prev_valid,
  input  logic [knp_pkg::DIST_W-1:0]  prev_dist,
  input  logic [IDX_W-1:0]            prev_idx,
  input  logic                        prev_lt,
  input  logic                        next_valid,
  input  logic [knp_pkg::DIST_W-1:0]  next_dist,
  input  logic [IDX_W-1:0]            next_idx,
  output logic                        valid,
  output logic [knp_pkg::DIST_W-1:0]  sq_dist,
  output logic [IDX_W-1:0]            idx,
  output logic                        lt
);

  logic                       valid_r, valid_nxt;
  logic [knp_pkg::DIST_W-1:0] dist_r, dist_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;

  // strict compare: equal distance stays behind the earlier point
  assign lt = !valid_r || (cand_dist < dist_r);

  always_comb begin
    valid_nxt = valid_r;
    dist_nxt  = dist_r;
    idx_nxt   = idx_r;
    if (ctl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl.shift) begin
      valid_nxt = next_valid;
      dist_nxt  = next_dist;
      idx_nxt   = next_idx;
    end else if (ctl.ins && lt) begin
      if (prev_lt) begin
        // candidate lands further up, take the neighbor's entry
        valid_nxt = prev_valid;
        dist_nxt  = prev_dist;
        idx_nxt   = prev_idx;
      end else begin
        valid_nxt = 1'b1;
        dist_nxt  = cand_dist;
        idx_nxt   = cand_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    idx_r  <= idx_nxt;
  end

  assign valid   = valid_r;
  assign sq_dist = dist_r;
  assign idx     = idx_r;

endmodule

@@ rtl/k_nearest_point_table_top.sv @@
// top level of the point table with k nearest search
//
//   channel | direction | handshake           | beat contents
//   in_     | input     | in_valid / in_stall  | op, pos_x, pos_y
//   out_    | output    | out_valid / out_stall| status, point_index, dist_sq, last
//   cfg_    | input     | cfg_valid / cfg_ready| k_neighbors
//
// insert, clear, unused op and a query on an empty table are handled without leaving idle
// a query scans every stored point (one table read per cycle through
// the point memory port and the distance pipeline), then emits one result beat per neighbor
// rst_n is synchronous; the table is empty and k_neighbors is 16 after reset
// out_stall holds the result register and the neighbor chain; in_stall is high
// while a query runs or the result register cannot be freed
`include "assert_macros.svh"
module k_nearest_point_table_top #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_K      = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [knp_pkg::OP_W-1:0]           in_op,
  input  logic signed [knp_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [knp_pkg::COORD_W-1:0] in_pos_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [knp_pkg::STAT_W-1:0]         out_status,
  output logic [knp_pkg::PIDX_W-1:0]         out_point_index,
  output logic [knp_pkg::DIST_W-1:0]         out_dist_sq,
  output logic                               out_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [knp_pkg::K_W-1:0]            cfg_k_neighbors
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int KW = knp_pkg::K_W;
  localparam int NW = (CW > KW) ? CW : KW;
  localparam int XW = knp_pkg::COORD_W;
  localparam int DW = knp_pkg::DIST_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_EMIT} state_t;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            scan_r, scan_nxt;
  logic [KW-1:0]            k_r;
  logic [KW-1:0]            emit_left_r, emit_left_nxt;
  logic signed [XW-1:0]     qx_r, qx_nxt, qy_r, qy_nxt;
  logic                     rd_valid_r;
  logic [AW-1:0]            rd_idx_r;
  logic                     out_valid_r, out_valid_nxt;
  logic [knp_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [knp_pkg::PIDX_W-1:0] out_index_r, out_index_nxt;
  logic [DW-1:0]            out_dist_r, out_dist_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     out_free, in_accept, table_full;
  logic [KW-1:0]            k_eff, n_report;
  logic                     ram_we;
  logic [2*XW-1:0]          ram_rdata;
  logic                     cand_valid, dist_busy;
  logic [AW-1:0]            cand_idx;
  logic [DW-1:0]            cand_dist;
  knp_pkg::cell_ctl_t       ctl;

  logic [MAX_K-1:0]         cell_valid, cell_lt;
  logic [DW-1:0]            cell_dist [MAX_K];
  logic [AW-1:0]            cell_idx  [MAX_K];

  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = !((state_r == S_IDLE) && out_free);
  assign in_accept  = in_valid && !in_stall;
  assign table_full = (count_r == CW'(MAX_POINTS));
  assign cfg_ready  = 1'b1;

  // zero acts as one, above the chain length acts as the chain length
  always_comb begin
    if (k_r == '0) begin
      k_eff = KW'(1);
    end else if (k_r > KW'(MAX_K)) begin
      k_eff = KW'(MAX_K);
    end else begin
      k_eff = k_r;
    end
    if (NW'(count_r) < NW'(k_eff)) begin
      n_report = KW'(count_r);
    end else begin
      n_report = k_eff;
    end
  end

  assign ram_we = in_accept && (in_op == knp_pkg::OP_INSERT) && !table_full;

  knp_ram #(
    .WIDTH (2 * XW),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_pos_x, in_pos_y}),
    .re    (state_r == S_SCAN),
    .raddr (scan_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  knp_dist #(
    .IDX_W (AW)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rd_valid_r),
    .in_idx    (rd_idx_r),
    .px        (ram_rdata[2*XW-1:XW]),
    .py        (ram_rdata[XW-1:0]),
    .qx        (qx_r),
    .qy        (qy_r),
    .out_valid (cand_valid),
    .out_idx   (cand_idx),
    .out_dist  (cand_dist),
    .busy      (dist_busy)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    emit_left_nxt  = emit_left_r;
    qx_nxt         = qx_r;
    qy_nxt         = qy_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_dist_nxt   = out_dist_r;
    out_last_nxt   = out_last_r;
    ctl.clr        = 1'b0;
    ctl.ins        = cand_valid;
    ctl.shift      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          out_index_nxt = '0;
          out_dist_nxt  = '0;
          out_last_nxt  = 1'b1;
          unique case (in_op)
            knp_pkg::OP_INSERT: begin
              out_valid_nxt = 1'b1;
              if (table_full) begin
                out_status_nxt = knp_pkg::ST_FULL;
              end else begin
                out_status_nxt = knp_pkg::ST_INSERTED;
                out_index_nxt  = knp_pkg::PIDX_W'(count_r);
                count_nxt      = count_r + CW'(1);
              end
            end
            knp_pkg::OP_CLEAR: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = knp_pkg::ST_CLEARED;
              count_nxt      = '0;
            end
            knp_pkg::OP_QUERY: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = knp_pkg::ST_EMPTY;
              end else begin
                ctl.clr       = 1'b1;
                qx_nxt        = in_pos_x;
                qy_nxt        = in_pos_y;
                scan_nxt      = '0;
                emit_left_nxt = n_report;
                state_nxt     = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        scan_nxt = scan_r + CW'(1);
        if (scan_r + CW'(1) == count_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_valid_r && !dist_busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ctl.shift      = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = knp_pkg::ST_NEIGHBOR;
          out_index_nxt  = knp_pkg::PIDX_W'(cell_idx[0]);
          out_dist_nxt   = cell_dist[0];
          out_last_nxt   = (emit_left_r == KW'(1));
          emit_left_nxt  = emit_left_r - KW'(1);
          if (emit_left_r == KW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      k_r         <= knp_pkg::K_RESET;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_valid_r  <= (state_r == S_SCAN);
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        k_r <= cfg_k_neighbors;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    emit_left_r  <= emit_left_nxt;
    qx_r         <= qx_nxt;
    qy_r         <= qy_nxt;
    rd_idx_r     <= scan_r[AW-1:0];
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_dist_r   <= out_dist_nxt;
    out_last_r   <= out_last_nxt;
  end

  // sorted chain, nearest in cell 0
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    logic          p_valid, p_lt, n_valid;
    logic [DW-1:0] p_dist, n_dist;
    logic [AW-1:0] p_idx, n_idx;

    if (i == 0) begin : g_head
      assign p_valid = 1'b0;
      assign p_dist  = '0;
      assign p_idx   = '0;
      assign p_lt    = 1'b0;
    end else begin : g_body
      assign p_valid = cell_valid[i-1];
      assign p_dist  = cell_dist[i-1];
      assign p_idx   = cell_idx[i-1];
      assign p_lt    = cell_lt[i-1];
    end

    if (i == MAX_K - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_dist  = '0;
      assign n_idx   = '0;
    end else begin : g_inner
      assign n_valid = cell_valid[i+1];
      assign n_dist  = cell_dist[i+1];
      assign n_idx   = cell_idx[i+1];
    end

    knp_cell #(
      .IDX_W (AW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .cand_dist  (cand_dist),
      .cand_idx   (cand_idx),
      .prev_valid (p_valid),
      .prev_dist  (p_dist),
      .prev_idx   (p_idx),
      .prev_lt    (p_lt),
      .next_valid (n_valid),
      .next_dist  (n_dist),
      .next_idx   (n_idx),
      .valid      (cell_valid[i]),
      .sq_dist    (cell_dist[i]),
      .idx        (cell_idx[i]),
      .lt         (cell_lt[i])
    );
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_point_index = out_index_r;
  assign out_dist_sq     = out_dist_r;
  assign out_last        = out_last_r;

  `KNP_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(MAX_POINTS), "count over table size")
  `KNP_ASSERT_IMP(a_emit_entry, clk, rst_n, state_r == S_EMIT, cell_valid[0], "emit from empty chain")
  `KNP_ASSERT_IMP(a_chain_prefix, clk, rst_n, 1'b1, ((cell_valid + MAX_K'(1)) & cell_valid) == '0, "chain has a hole")
  `KNP_ASSERT_IMP(a_nonlast_emit, clk, rst_n, out_valid_r && !out_last_r, state_r == S_EMIT, "open result outside emit")
  `KNP_ASSERT_NXT(a_query_scans, clk, rst_n, in_accept && in_op == knp_pkg::OP_QUERY && count_r != '0, state_r == S_SCAN && !cell_valid[0], "query did not start scan")

endmodule
